// ===== hw/rtl/oidtxt_pkg.sv =====
`timescale 1ns / 1ps

package oidtxt_pkg;

  localparam int BYTE_W   = 8;
  localparam int DIGIT_W  = 4;

  // First content byte split points
  localparam logic [BYTE_W-1:0] FIRST_SPLIT = 8'd80;
  localparam logic [BYTE_W-1:0] ARC_DIV     = 8'd40;

  // Continuation flag position and payload mask of a content byte
  localparam int                MORE_BIT = 7;
  localparam logic [BYTE_W-1:0] LOW_BITS = 8'h7F;

  // ASCII codes
  localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

endpackage

// ===== hw/rtl/oidtxt_if.sv =====
`timescale 1ns / 1ps

interface oidtxt_in_if
  import oidtxt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] content_byte;
  logic              first_of_oid;

  modport source (output valid, output content_byte, output first_of_oid, input ready);
  modport sink   (input valid, input content_byte, input first_of_oid, output ready);
endinterface

interface oidtxt_out_if
  import oidtxt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              last_char;
  logic              arc_overflow;

  modport source (output valid, output out_char, output last_char, output arc_overflow,
                  input ready);
  modport sink   (input valid, input out_char, input last_char, input arc_overflow,
                  output ready);
endinterface

// ===== hw/rtl/oid_bytes_to_dotted_text_core.sv =====
`timescale 1ns / 1ps
// DER object identifier content bytes in, dotted decimal ASCII text out.
// Channel content (sink): one content byte per transaction, with first_of_oid
//   marking the first byte of a new identifier. Ready is high only while the
//   block is idle; it works on one byte at a time.
// Channel text (source): one character per transaction ('.' or a digit), with
//   last_char on the final character caused by a byte and arc_overflow on the
//   characters of an arc that lost bits beyond ARC_BITS.
// A first byte gives "h.l"; a byte with bit 7 clear ends an arc and gives
//   ".digits"; a byte with bit 7 set (not first) only feeds the accumulator
//   and is done in the cycle it is accepted.
// Steps: an accepted arc-ending byte runs bit-serial binary-to-BCD conversion
//   (shift-add-3) over all ARC_BITS bits of the arc, then sends the dot, then
//   skips leading zero digits and sends each remaining digit; a first byte
//   also sends its first arc digit ahead of the dot.
// When the receiver stalls, the output register holds its character and the
//   emitter waits; no character is lost or repeated.
// Reset (synchronous, active high) clears the accumulator, the overflow flag,
//   the output valid and returns the block to idle, ready for a byte.
module oid_bytes_to_dotted_text_core
  import oidtxt_pkg::*;
#(
  parameter int ARC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  oidtxt_in_if.sink          content,
  oidtxt_out_if.source       text
);

  // Decimal digits needed for ARC_BITS bits: floor(ARC_BITS * log10(2)) + 1
  localparam int NDIG   = (ARC_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * DIGIT_W;
  localparam int CNT_W  = $clog2(ARC_BITS);
  localparam int DIG_W  = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    EMIT
  } state_t;

  state_t              state;
  logic [ARC_BITS-1:0] acc;
  logic                ovf_seen;
  logic [ARC_BITS-1:0] bin;
  logic [BCD_W-1:0]    bcd;
  logic [CNT_W-1:0]    cnt;
  logic [DIG_W-1:0]    dig_left;
  logic                pend_hi;
  logic                pend_dot;
  logic                started;
  logic [1:0]          hi_digit;
  logic                arc_ovf;

  logic                accept;
  logic                out_free;
  logic                skip_zero;
  logic                emit;
  logic [ARC_BITS-1:0] acc_shift;
  logic                ovf_now;
  logic [1:0]          first_hi;
  logic [BYTE_W-1:0]   first_lo;
  logic [BCD_W-1:0]    bcd_adj;
  logic [DIGIT_W-1:0]  top_digit;

  assign content.ready = (state == IDLE);
  assign accept        = content.valid && content.ready;
  assign out_free      = !text.valid || text.ready;

  // Gather seven more bits; flag any bits pushed out of the top
  assign ovf_now   = (acc[ARC_BITS-1 -: 7] != 7'd0);
  assign acc_shift = {acc[ARC_BITS-8:0], content.content_byte[6:0] & LOW_BITS[6:0]};

  // Split of the first byte by compare and subtract
  always_comb begin
    if (content.content_byte >= FIRST_SPLIT) begin
      first_hi = 2'd2;
      first_lo = content.content_byte - FIRST_SPLIT;
    end else if (content.content_byte >= ARC_DIV) begin
      first_hi = 2'd1;
      first_lo = content.content_byte - ARC_DIV;
    end else begin
      first_hi = 2'd0;
      first_lo = content.content_byte;
    end
  end

  // Add 3 to every BCD digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

  // Skip a leading zero digit; load a character whenever the register is free
  assign skip_zero = !pend_hi && !pend_dot && !started && (top_digit == '0) &&
                     (dig_left > DIG_W'(1));
  assign emit      = (state == EMIT) && out_free && !skip_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      acc        <= '0;
      ovf_seen   <= 1'b0;
      text.valid <= 1'b0;
      pend_hi    <= 1'b0;
      pend_dot   <= 1'b0;
      started    <= 1'b0;
    end else begin
      // Raise valid on a new character; drop it once the receiver takes it
      if (emit) begin
        text.valid <= 1'b1;
      end else if (text.ready) begin
        text.valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            if (content.first_of_oid) begin
              // New identifier: drop any unfinished arc, print both first arcs
              acc      <= '0;
              ovf_seen <= 1'b0;
              pend_hi  <= 1'b1;
              pend_dot <= 1'b1;
              hi_digit <= first_hi;
              arc_ovf  <= 1'b0;
              bin      <= {{(ARC_BITS-BYTE_W){1'b0}}, first_lo};
              bcd      <= '0;
              cnt      <= CNT_W'(ARC_BITS - 1);
              state    <= CONV;
            end else if (!content.content_byte[MORE_BIT]) begin
              // Arc ends: convert it, then clear the accumulator
              acc      <= '0;
              ovf_seen <= 1'b0;
              pend_hi  <= 1'b0;
              pend_dot <= 1'b1;
              arc_ovf  <= ovf_seen || ovf_now;
              bin      <= acc_shift;
              bcd      <= '0;
              cnt      <= CNT_W'(ARC_BITS - 1);
              state    <= CONV;
            end else begin
              // Arc goes on: keep gathering
              acc      <= acc_shift;
              ovf_seen <= ovf_seen || ovf_now;
            end
          end
        end

        CONV: begin
          bcd <= {bcd_adj[BCD_W-2:0], bin[ARC_BITS-1]};
          bin <= {bin[ARC_BITS-2:0], 1'b0};
          if (cnt == '0) begin
            dig_left <= DIG_W'(NDIG);
            started  <= 1'b0;
            state    <= EMIT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        EMIT: begin
          if (pend_hi) begin
            if (out_free) begin
              text.out_char     <= CHAR_ZERO + {6'd0, hi_digit};
              text.last_char    <= 1'b0;
              text.arc_overflow <= 1'b0;
              pend_hi           <= 1'b0;
            end
          end else if (pend_dot) begin
            if (out_free) begin
              text.out_char     <= CHAR_DOT;
              text.last_char    <= 1'b0;
              text.arc_overflow <= arc_ovf;
              pend_dot          <= 1'b0;
            end
          end else if (skip_zero) begin
            bcd      <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_left <= dig_left - 1'b1;
          end else if (out_free) begin
            text.out_char     <= CHAR_ZERO + {4'd0, top_digit};
            text.last_char    <= (dig_left == DIG_W'(1));
            text.arc_overflow <= arc_ovf;
            started           <= 1'b1;
            bcd               <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_left          <= dig_left - 1'b1;
            if (dig_left == DIG_W'(1)) begin
              state <= IDLE;
            end
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_oid_bytes_to_dotted_text_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the OID content byte to dotted text converter.
// An in-bench predictor mirrors the accumulator and the overflow flag.
// It queues the characters that each accepted byte should produce.
// The checker pops one expectation per text transaction and compares fields.
module tb_oid_bytes_to_dotted_text_core;
  import oidtxt_pkg::*;

  localparam int ARC_BITS     = 32;
  // Arc-ending bytes go through conversion and digit output inside the block.
  localparam int DRAIN_CYCLES = ARC_BITS + 32;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
    logic              lost;
  } text_char_t;

  // Receiver stall patterns, each held for a random span before a new one is picked.
  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_LONG_STALLS,
    RX_MOSTLY_READY
  } rx_mode_t;

  logic clk;
  logic rst;

  oidtxt_in_if  content_ch ();
  oidtxt_out_if text_ch ();

  oid_bytes_to_dotted_text_core #(
    .ARC_BITS (ARC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .content (content_ch),
    .text    (text_ch)
  );

  // Predictor state: the arc being gathered and whether it lost high bits.
  logic [ARC_BITS-1:0] arc_acc  = '0;
  logic                arc_lost = 1'b0;

  text_char_t expected_text[$];
  int         error_count = 0;
  int         bytes_sent  = 0;
  int         burst_left  = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop; far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic push_char(input logic [BYTE_W-1:0] code, input logic lost);
    text_char_t c;
    c.code = code;
    c.last = 1'b0;
    c.lost = lost;
    expected_text.push_back(c);
  endtask

  // Queue the decimal digits of value, most significant first, no leading zeros.
  task automatic push_decimal(input logic [ARC_BITS-1:0] value, input logic lost);
    logic [3:0]          digit_stack [0:19];
    logic [ARC_BITS-1:0] rest;
    int                  n;
    rest = value;
    n = 0;
    do begin
      digit_stack[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end while (rest != 0);
    while (n > 0) begin
      n--;
      push_char(CHAR_ZERO + digit_stack[n], lost);
    end
  endtask

  // Work out the characters that one accepted content byte causes.
  task automatic predict_text(input logic [BYTE_W-1:0] b, input logic is_first);
    int                start;
    text_char_t        tail;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    start = expected_text.size();
    if (is_first) begin
      // A new identifier drops any unfinished arc.
      arc_acc  = '0;
      arc_lost = 1'b0;
      if (b >= FIRST_SPLIT) begin
        hi = 8'd2;
        lo = b - FIRST_SPLIT;
      end else begin
        hi = b / ARC_DIV;
        lo = b % ARC_DIV;
      end
      push_decimal(ARC_BITS'(hi), 1'b0);
      push_char(CHAR_DOT, 1'b0);
      push_decimal(ARC_BITS'(lo), 1'b0);
    end else begin
      if ((arc_acc >> (ARC_BITS - 7)) != 0) begin
        arc_lost = 1'b1;
      end
      arc_acc = (arc_acc << 7) | ARC_BITS'(b & LOW_BITS);
      if (!b[MORE_BIT]) begin
        push_char(CHAR_DOT, arc_lost);
        push_decimal(arc_acc, arc_lost);
        arc_acc  = '0;
        arc_lost = 1'b0;
      end
    end
    // Mark the final character of this byte.
    if (expected_text.size() > start) begin
      tail = expected_text[expected_text.size() - 1];
      tail.last = 1'b1;
      expected_text[expected_text.size() - 1] = tail;
    end
  endtask

  // Send one content byte. The sender runs in bursts; between bursts it mostly drops
  // valid for a random gap, so gaps land on every phase of the conversion.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        content_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    content_ch.valid        = 1'b1;
    content_ch.content_byte = b;
    content_ch.first_of_oid = is_first;
    do @(posedge clk); while (!content_ch.ready);
    predict_text(b, is_first);
    bytes_sent++;
  endtask

  // Hold the sender idle until every queued character has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    content_ch.valid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  // Receiver: change ready at the falling edge, following a pattern of its own.
  initial begin
    rx_mode_t mode;
    int       span;
    int       stall_left;
    text_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_STREAM: begin
            text_ch.ready = 1'b1;
          end
          RX_COIN: begin
            text_ch.ready = 1'($urandom_range(0, 1));
          end
          RX_LONG_STALLS: begin
            if (stall_left > 0) begin
              text_ch.ready = 1'b0;
              stall_left--;
            end else begin
              text_ch.ready = 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
            end
          end
          default: begin
            text_ch.ready = ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Checker: compare each text transaction against the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected character", text_ch.out_char, 0);
      end else begin
        want = expected_text.pop_front();
        if (text_ch.out_char !== want.code) begin
          report_mismatch("out_char", text_ch.out_char, want.code);
        end
        if (text_ch.last_char !== want.last) begin
          report_mismatch("last_char", text_ch.last_char, want.last);
        end
        if (text_ch.arc_overflow !== want.lost) begin
          report_mismatch("arc_overflow", text_ch.arc_overflow, want.lost);
        end
      end
    end
  end

  // Bytes after reset without a first mark act as later bytes on a clear arc.
  task automatic test_unmarked_start();
    send_byte(8'h05, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // First-byte split around both boundaries, plus bytes with bit 7 set.
  task automatic test_first_byte_split();
    send_byte(8'd0, 1'b1);
    send_byte(8'd39, 1'b1);
    send_byte(8'd40, 1'b1);
    send_byte(8'd79, 1'b1);
    send_byte(8'd80, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Single-byte arcs at both extremes and a two-byte arc.
  task automatic test_arc_endings();
    send_byte(8'h2B, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h86, 1'b0);
    send_byte(8'h48, 1'b0);
  endtask

  // A new identifier mark drops an arc that is still being gathered.
  task automatic test_dropped_arc();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h2A, 1'b1);
    send_byte(8'h01, 1'b0);
  endtask

  // Widest arc that fits (all ones, ten digits), then one bit too many.
  task automatic test_arc_width_limit();
    send_byte(8'h8F, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h9F, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Next arc must start with a clear overflow flag.
    send_byte(8'h11, 1'b0);
  endtask

  initial begin
    content_ch.valid        = 1'b0;
    content_ch.content_byte = '0;
    content_ch.first_of_oid = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_unmarked_start();
    test_first_byte_split();
    test_arc_endings();
    test_dropped_arc();
    test_arc_width_limit();
    test_random_oids();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) begin
      report_mismatch("characters still pending", expected_text.size(), 0);
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Mostly well-formed identifiers with random arcs; some noise and some
  // identifiers cut off in the middle of an arc.
  task automatic test_random_oids();
    int   start;
    int   n_arcs;
    int   len;
    logic paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < 70) begin
      // Let everything drain once halfway through before going on.
      if (!paused && bytes_sent - start >= 35) begin
        wait_for_drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any byte, any mark.
        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        n_arcs = $urandom_range(0, 4);
        repeat (n_arcs) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
          repeat (len - 1) send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
          // Now and then cut the identifier off in the middle of an arc.
          if ($urandom_range(0, 11) != 0) begin
            send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
          end
        end
      end
    end
  endtask

endmodule

// ===== oid_bytes_to_dotted_text_core.f =====
hw/rtl/oidtxt_pkg.sv
hw/rtl/oidtxt_if.sv
hw/rtl/oid_bytes_to_dotted_text_core.sv
tb/tb_oid_bytes_to_dotted_text_core.sv
